// ===== rtl/core/fraction_arith_reduce_assert.svh =====
// Assertion macros used by the checker file.
// Each macro expands to one labeled concurrent assertion.
`ifndef FRACTION_ARITH_REDUCE_ASSERT_SVH
`define FRACTION_ARITH_REDUCE_ASSERT_SVH

// Same-cycle implication.
`define FRAC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define FRAC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/frac_pkg.sv =====
// ----------------------------------------------------------------------------
// frac_pkg
// Widths and operation codes for the fraction arithmetic block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package frac_pkg;

   localparam int OPERAND_WIDTH = 16;
   localparam int RESULT_WIDTH  = 2 * OPERAND_WIDTH + 1;

   typedef logic [1:0] command_type;

   localparam command_type OP_ADD = 2'd0;
   localparam command_type OP_SUB = 2'd1;
   localparam command_type OP_MUL = 2'd2;
   localparam command_type OP_DIV = 2'd3;

endpackage

// ===== rtl/core/fraction_arith_reduce.sv =====
// ----------------------------------------------------------------------------
// fraction_arith_reduce
// Sequence: MUL0, MUL1, MUL2 multiply steps, SETUP, then one RESULT_WIDTH-bit
//   divide per Euclid remainder step (none on a zero numerator) and one for each
//   of the two quotients before rsp_valid; on error SETUP goes straight to DONE.
// Busy: one request at a time; req_stall stays high until the result word is
//   taken, and the single shift/subtract divider serves every divide step.
// Reset: synchronous, active high; returns to idle, no result pending.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fraction_arith_reduce
   import frac_pkg::*;
(
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [1:0]                     req_command,
   input  logic signed [OPERAND_WIDTH-1:0] req_num_a,
   input  logic signed [OPERAND_WIDTH-1:0] req_den_a,
   input  logic signed [OPERAND_WIDTH-1:0] req_num_b,
   input  logic signed [OPERAND_WIDTH-1:0] req_den_b,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic signed [RESULT_WIDTH-1:0] rsp_reduced_num,
   output logic signed [RESULT_WIDTH-1:0] rsp_result_den,
   output logic                           rsp_error
);

   localparam int W     = RESULT_WIDTH;
   localparam int PW    = 2 * OPERAND_WIDTH;
   localparam int CNT_W = $clog2(W);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(W - 1);

   // Sequencer states
   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_MUL0  = 4'd1;  // first product
   localparam logic [3:0] ST_MUL1  = 4'd2;  // cross product, add/sub only
   localparam logic [3:0] ST_MUL2  = 4'd3;  // denominator product
   localparam logic [3:0] ST_SETUP = 4'd4;  // magnitudes, zero checks
   localparam logic [3:0] ST_GCD   = 4'd5;  // b % a on the divider
   localparam logic [3:0] ST_QNUM  = 4'd6;  // |num| / gcd
   localparam logic [3:0] ST_QDEN  = 4'd7;  // |den| / gcd
   localparam logic [3:0] ST_DONE  = 4'd8;  // result word held for rsp side

   logic [3:0]                     state_ff, state_in;
   command_type                    cmd_ff, cmd_in;
   logic signed [OPERAND_WIDTH-1:0] na_ff, na_in, da_ff, da_in;
   logic signed [OPERAND_WIDTH-1:0] nb_ff, nb_in, db_ff, db_in;
   logic signed [W-1:0]            rn_ff, rn_in, rd_ff, rd_in;
   logic [W-1:0]                   ga_ff, ga_in, gb_ff, gb_in;
   logic [W-1:0]                   div_quo_ff, div_quo_in;
   logic [W-1:0]                   div_rem_ff, div_rem_in;
   logic [CNT_W-1:0]               cnt_ff, cnt_in;
   logic signed [W-1:0]            res_num_ff, res_num_in, res_den_ff, res_den_in;
   logic                           res_err_ff, res_err_in;

   // Shared multiplier
   logic signed [OPERAND_WIDTH-1:0] mul_x, mul_y;
   logic signed [PW-1:0]           prod;
   logic signed [W-1:0]            prod_ext;

   // Shared divider step
   logic [W-1:0] divisor;
   logic [W:0]   rem_sh;
   logic         step_ge;
   logic [W:0]   rem_diff;
   logic [W-1:0] rem_nx, quo_nx;
   logic         div_last;

   logic [W-1:0] mag_n, mag_d;
   logic         accept;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);

   // Operand selection per multiply step
   always_comb begin
      unique case (state_ff)
         ST_MUL0: begin
            mul_x = na_ff;
            mul_y = (cmd_ff == OP_MUL) ? nb_ff : db_ff;
         end
         ST_MUL1: begin
            mul_x = nb_ff;
            mul_y = da_ff;
         end
         ST_MUL2: begin
            mul_x = da_ff;
            mul_y = (cmd_ff == OP_DIV) ? nb_ff : db_ff;
         end
         default: begin
            mul_x = '0;
            mul_y = '0;
         end
      endcase
   end

   assign prod     = mul_x * mul_y;
   assign prod_ext = {prod[PW-1], prod};

   // Restoring divide, one quotient bit per cycle
   assign divisor  = (state_ff == ST_GCD) ? ga_ff : gb_ff;
   assign rem_sh   = {div_rem_ff, div_quo_ff[W-1]};
   assign step_ge  = (rem_sh >= {1'b0, divisor});
   assign rem_diff = rem_sh - {1'b0, divisor};
   assign rem_nx   = step_ge ? rem_diff[W-1:0] : rem_sh[W-1:0];
   assign quo_nx   = {div_quo_ff[W-2:0], step_ge};
   assign div_last = (cnt_ff == CNT_LAST);

   // Magnitudes; |raw| <= 2^31 so W bits hold them unsigned
   assign mag_n = rn_ff[W-1] ? (W'(0) - rn_ff) : rn_ff;
   assign mag_d = rd_ff[W-1] ? (W'(0) - rd_ff) : rd_ff;

   always_comb begin
      state_in   = state_ff;
      cmd_in     = cmd_ff;
      na_in      = na_ff;
      da_in      = da_ff;
      nb_in      = nb_ff;
      db_in      = db_ff;
      rn_in      = rn_ff;
      rd_in      = rd_ff;
      ga_in      = ga_ff;
      gb_in      = gb_ff;
      div_quo_in = div_quo_ff;
      div_rem_in = div_rem_ff;
      cnt_in     = cnt_ff;
      res_num_in = res_num_ff;
      res_den_in = res_den_ff;
      res_err_in = res_err_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd_in   = req_command;
               na_in    = req_num_a;
               da_in    = req_den_a;
               nb_in    = req_num_b;
               db_in    = req_den_b;
               state_in = ST_MUL0;
            end
         end
         ST_MUL0: begin
            rn_in    = prod_ext;
            state_in = ST_MUL1;
         end
         ST_MUL1: begin
            if (cmd_ff == OP_ADD) begin
               rn_in = rn_ff + prod_ext;
            end else if (cmd_ff == OP_SUB) begin
               rn_in = rn_ff - prod_ext;
            end
            state_in = ST_MUL2;
         end
         ST_MUL2: begin
            rd_in    = prod_ext;
            state_in = ST_SETUP;
         end
         ST_SETUP: begin
            ga_in      = mag_n;
            gb_in      = mag_d;
            div_rem_in = '0;
            cnt_in     = '0;
            if (mag_n == '0 && mag_d == '0) begin
               // gcd would be zero: flag it, return zeros
               res_num_in = '0;
               res_den_in = '0;
               res_err_in = 1'b1;
               state_in   = ST_DONE;
            end else if (mag_n == '0) begin
               div_quo_in = mag_n;
               state_in   = ST_QNUM;
            end else begin
               div_quo_in = mag_d;
               state_in   = ST_GCD;
            end
         end
         ST_GCD: begin
            div_rem_in = rem_nx;
            div_quo_in = quo_nx;
            cnt_in     = cnt_ff + 1'b1;
            if (div_last) begin
               // b <- a, a <- b % a; gcd ends up in gb
               ga_in      = rem_nx;
               gb_in      = ga_ff;
               div_rem_in = '0;
               cnt_in     = '0;
               if (rem_nx == '0) begin
                  div_quo_in = mag_n;
                  state_in   = ST_QNUM;
               end else begin
                  div_quo_in = ga_ff;
               end
            end
         end
         ST_QNUM: begin
            div_rem_in = rem_nx;
            div_quo_in = quo_nx;
            cnt_in     = cnt_ff + 1'b1;
            if (div_last) begin
               res_num_in = rn_ff[W-1] ? (W'(0) - quo_nx) : quo_nx;
               div_quo_in = mag_d;
               div_rem_in = '0;
               cnt_in     = '0;
               state_in   = ST_QDEN;
            end
         end
         ST_QDEN: begin
            div_rem_in = rem_nx;
            div_quo_in = quo_nx;
            cnt_in     = cnt_ff + 1'b1;
            if (div_last) begin
               res_den_in = rd_ff[W-1] ? (W'(0) - quo_nx) : quo_nx;
               res_err_in = 1'b0;
               cnt_in     = '0;
               state_in   = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_stall) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   // Payload, no reset needed
   always_ff @(posedge clock) begin
      cmd_ff     <= cmd_in;
      na_ff      <= na_in;
      da_ff      <= da_in;
      nb_ff      <= nb_in;
      db_ff      <= db_in;
      rn_ff      <= rn_in;
      rd_ff      <= rd_in;
      ga_ff      <= ga_in;
      gb_ff      <= gb_in;
      div_quo_ff <= div_quo_in;
      div_rem_ff <= div_rem_in;
      res_num_ff <= res_num_in;
      res_den_ff <= res_den_in;
      res_err_ff <= res_err_in;
   end

   assign rsp_valid       = (state_ff == ST_DONE);
   assign rsp_reduced_num = res_num_ff;
   assign rsp_result_den  = res_den_ff;
   assign rsp_error       = res_err_ff;

endmodule

// ===== rtl/core/frac_checker.sv =====
// ----------------------------------------------------------------------------
// frac_checker
// Port-level checks for fraction_arith_reduce, bound into every instance of it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "fraction_arith_reduce_assert.svh"

module frac_checker
   import frac_pkg::*;
(
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_stall,
   input logic [1:0]                      req_command,
   input logic signed [OPERAND_WIDTH-1:0] req_num_a,
   input logic signed [OPERAND_WIDTH-1:0] req_den_a,
   input logic signed [OPERAND_WIDTH-1:0] req_num_b,
   input logic signed [OPERAND_WIDTH-1:0] req_den_b,
   input logic                            rsp_valid,
   input logic                            rsp_stall,
   input logic signed [RESULT_WIDTH-1:0]  rsp_reduced_num,
   input logic signed [RESULT_WIDTH-1:0]  rsp_result_den,
   input logic                            rsp_error
);

   // stalled result word stays offered
   `FRAC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid, "rsp word dropped")

   // error word carries zeros
   `FRAC_ASSERT_NOW(a_err_zero, clock, reset, rsp_valid && rsp_error, (rsp_reduced_num == '0) && (rsp_result_den == '0), "error word not zero")

   // no new request taken while a result is pending
   `FRAC_ASSERT_NOW(a_busy_out, clock, reset, rsp_valid, req_stall, "req open with result pending")

   // an accepted word never yields a result on the next cycle
   `FRAC_ASSERT_NEXT(a_min_latency, clock, reset, req_valid && !req_stall, req_stall && !rsp_valid, "result too early")

endmodule

bind fraction_arith_reduce frac_checker u_frac_checker (.*);
